/* rtl/tgrr_pkg.sv */
// Shared constants for the text glyph row renderer.
// Register indexes, field widths and the shade patterns; no dependencies.
package tgrr_pkg;

  // Widest glyph row the font storage supports
  localparam int unsigned MaxGlyphWidth = 16;
  // Pixels a row can carry: bounded by the 16 font bits and the glyph size
  localparam int unsigned RowLimit      = (MaxGlyphWidth < 16) ? MaxGlyphWidth : 16;

  localparam int unsigned RowW    = 16;
  localparam int unsigned ColourW = 4;
  localparam int unsigned AttrW   = 8;
  localparam int unsigned WidthW  = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PixIdxW = 4;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_TEXT_COLOUR   = 3'd0,
    REG_INVERT_ENABLE = 3'd1,
    REG_SHADE_ENABLE  = 3'd2,
    REG_TEXT_MODE     = 3'd3,
    REG_GLYPH_WIDTH   = 3'd4
  } cfg_reg_e;

  // Reset values
  localparam logic [AttrW-1:0]  TextColourRst = 8'h0F;
  localparam logic [WidthW-1:0] GlyphWidthRst = 5'd8;

  // Checker shade patterns, even and odd rows
  localparam logic [RowW-1:0] ShadeEven = 16'hAAAA;
  localparam logic [RowW-1:0] ShadeOdd  = 16'h5555;

  localparam logic [WidthW-1:0] RowLimitW = WidthW'(RowLimit);

endpackage

/* rtl/text_glyph_row_renderer_top.sv */
// Top level of the text glyph row renderer: row register, pixel serializer
// and output register. Depends on tgrr_pkg.

// Takes one glyph row per transaction and emits one pixel per cycle, left to
// right, while the output accepts them, so a row gives glyph_width pixels
// (8 for the usual 8-wide font, at most 16; a width of zero emits nothing).
// The pixel serializer is the limiting unit: the next row is accepted in the
// same cycle the last pixel of the current row moves to the output register,
// so rows stream back to back with no gap. Inversion and shading are applied
// when the row is accepted; colours come from the attribute register, which
// must only be written while the block is idle. The shade phase restarts on
// a row flagged as the first row of a glyph and toggles after every row.
module text_glyph_row_renderer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [tgrr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tgrr_pkg::AttrW-1:0]    cfg_wdata_i,
  // glyph row stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [15:0]                   s_axis_tdata_i,  // [15:0] glyph_row
  input  logic                          s_axis_tuser_i,  // [0] first_row
  // pixel stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o,  // [3:0] pixel_colour, [7:4] zero
  output logic                          m_axis_tlast_o   // last_pixel
);

  // Configuration registers
  logic [tgrr_pkg::AttrW-1:0]  text_colour_q;
  logic                        invert_enable_q;
  logic                        shade_enable_q;
  logic                        text_mode_q;
  logic [tgrr_pkg::WidthW-1:0] glyph_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_colour_q   <= tgrr_pkg::TextColourRst;
      invert_enable_q <= 1'b0;
      shade_enable_q  <= 1'b0;
      text_mode_q     <= 1'b0;
      glyph_width_q   <= tgrr_pkg::GlyphWidthRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tgrr_pkg::REG_TEXT_COLOUR:   text_colour_q   <= cfg_wdata_i;
        tgrr_pkg::REG_INVERT_ENABLE: invert_enable_q <= cfg_wdata_i[0];
        tgrr_pkg::REG_SHADE_ENABLE:  shade_enable_q  <= cfg_wdata_i[0];
        tgrr_pkg::REG_TEXT_MODE:     text_mode_q     <= cfg_wdata_i[0];
        tgrr_pkg::REG_GLYPH_WIDTH:   glyph_width_q   <= cfg_wdata_i[tgrr_pkg::WidthW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake plumbing
  logic out_valid_q;
  logic row_valid_q;
  logic out_free;
  logic pix_move;
  logic row_done;
  logic in_acc;

  logic [tgrr_pkg::PixIdxW-1:0] cnt_q, cnt_d;
  logic [tgrr_pkg::PixIdxW-1:0] last_idx_q;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign pix_move        = row_valid_q && out_free;
  assign row_done        = pix_move && (cnt_q == last_idx_q);
  assign s_axis_tready_o = !row_valid_q || row_done;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Row modification at accept: inversion, then shade overlay
  logic                        shade_phase_q, shade_phase_d;
  logic                        phase_eff;
  logic                        do_inv;
  logic [tgrr_pkg::RowW-1:0]   row_mod;
  logic [tgrr_pkg::WidthW-1:0] width_clamped;

  always_comb begin
    phase_eff = s_axis_tuser_i ? 1'b0 : shade_phase_q;
    do_inv    = invert_enable_q || (text_colour_q[7] && !text_mode_q);
    row_mod   = s_axis_tdata_i;
    if (invert_enable_q || shade_enable_q) begin
      if (do_inv) begin
        row_mod = ~row_mod;
      end
      if (shade_enable_q) begin
        row_mod = row_mod | (phase_eff ? tgrr_pkg::ShadeOdd : tgrr_pkg::ShadeEven);
      end
    end
    width_clamped = (glyph_width_q > tgrr_pkg::RowLimitW) ? tgrr_pkg::RowLimitW
                                                          : glyph_width_q;
    shade_phase_d = in_acc ? !phase_eff : shade_phase_q;
  end

  // Row register: the modified bits shift left one per emitted pixel
  logic [tgrr_pkg::RowW-1:0] row_q, row_d;
  logic                      row_valid_d;
  logic [tgrr_pkg::WidthW-1:0] width_m1;

  assign width_m1 = width_clamped - tgrr_pkg::WidthW'(1);

  always_comb begin
    row_valid_d = row_valid_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    if (pix_move) begin
      row_d = {row_q[tgrr_pkg::RowW-2:0], 1'b0};
      cnt_d = cnt_q + tgrr_pkg::PixIdxW'(1);
    end
    if (row_done) begin
      row_valid_d = 1'b0;
    end
    if (in_acc) begin
      // a zero-width row emits nothing
      row_valid_d = (width_clamped != '0);
      row_d       = row_mod;
      cnt_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q   <= 1'b0;
      shade_phase_q <= 1'b0;
      cnt_q         <= '0;
    end else begin
      row_valid_q   <= row_valid_d;
      shade_phase_q <= shade_phase_d;
      cnt_q         <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    if (in_acc) begin
      last_idx_q <= width_m1[tgrr_pkg::PixIdxW-1:0];
    end
  end

  // Output register: colour lookup of the leftmost remaining bit
  logic [tgrr_pkg::ColourW-1:0] pix_q;
  logic                         last_q;
  logic [tgrr_pkg::ColourW-1:0] fg;
  logic [tgrr_pkg::ColourW-1:0] bg;

  assign fg = text_colour_q[3:0];
  assign bg = {1'b0, text_colour_q[6:4]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pix_move;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_move) begin
      pix_q  <= row_q[tgrr_pkg::RowW-1] ? fg : bg;
      last_q <= (cnt_q == last_idx_q);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000, pix_q};
  assign m_axis_tlast_o  = last_q;

endmodule

/* tb/tgrr_checker.sv */
// Pixel checker for the text glyph row renderer: predicts the pixel stream of
// every accepted glyph row and compares it with the block's output stream.
// Depends on tgrr_pkg for the register indexes, reset values and patterns.
`timescale 1ns / 100ps

module tgrr_pixel_checker
  import tgrr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AttrW-1:0]   cfg_wdata_i,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_o,
  input  logic [15:0]        s_axis_tdata_i,  // [15:0] glyph_row
  input  logic               s_axis_tuser_i,  // [0] first_row
  input  logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  input  logic [7:0]         m_axis_tdata_o,  // [3:0] pixel_colour, [7:4] zero
  input  logic               m_axis_tlast_o,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [ColourW-1:0] colour;
    logic               last;
  } pixel_t;

  // Shadow copy of the registers and the shade phase
  logic [AttrW-1:0]  colour_q;
  logic              invert_q;
  logic              shade_q;
  logic              mode_q;
  logic [WidthW-1:0] width_q;
  logic              phase_q;

  pixel_t expected_pixels_q[$];

  // Compare the output transaction first, then predict the new row
  always @(posedge clk_i or negedge rst_ni) begin : pixel_model
    logic [RowW-1:0]   bits;
    logic [WidthW-1:0] count;
    logic              invert;
    pixel_t            pix;
    if (!rst_ni) begin
      colour_q  = TextColourRst;
      invert_q  = 1'b0;
      shade_q   = 1'b0;
      mode_q    = 1'b0;
      width_q   = GlyphWidthRst;
      phase_q   = 1'b0;
      expected_pixels_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_pixels_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected pixel: expected none, got tdata %02h last %0b",
                   $realtime, m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          pix = expected_pixels_q.pop_front();
          if (m_axis_tdata_o[3:0] !== pix.colour) begin
            errors_o++;
            $display("%0t: pixel colour mismatch: expected %0d, got %0d",
                     $realtime, pix.colour, m_axis_tdata_o[3:0]);
          end
          if (m_axis_tdata_o[7:4] !== 4'd0) begin
            errors_o++;
            $display("%0t: tdata padding mismatch: expected 0, got %0h",
                     $realtime, m_axis_tdata_o[7:4]);
          end
          if (m_axis_tlast_o !== pix.last) begin
            errors_o++;
            $display("%0t: tlast mismatch: expected %0b, got %0b",
                     $realtime, pix.last, m_axis_tlast_o);
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_o) begin
        bits = s_axis_tdata_i;
        if (s_axis_tuser_i) phase_q = 1'b0;
        // attribute bit 7 only matters while the row is being modified
        if (invert_q || shade_q) begin
          invert = invert_q || (colour_q[7] && !mode_q);
          if (invert) bits = ~bits;
          if (shade_q) bits = bits | (phase_q ? ShadeOdd : ShadeEven);
        end
        count = (width_q > RowLimitW) ? RowLimitW : width_q;
        for (int i = 0; i < count; i++) begin
          pix.colour = bits[15-i] ? colour_q[3:0] : {1'b0, colour_q[6:4]};
          pix.last   = (i == count - 1);
          expected_pixels_q.push_back(pix);
        end
        phase_q = ~phase_q;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TEXT_COLOUR:   colour_q = cfg_wdata_i;
          REG_INVERT_ENABLE: invert_q = cfg_wdata_i[0];
          REG_SHADE_ENABLE:  shade_q  = cfg_wdata_i[0];
          REG_TEXT_MODE:     mode_q   = cfg_wdata_i[0];
          REG_GLYPH_WIDTH:   width_q  = cfg_wdata_i[WidthW-1:0];
          default: ;
        endcase
      end

      pending_o = expected_pixels_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// Testbench top for the text glyph row renderer: clock, reset, register
// writes, glyph row stimulus and output back-pressure; verdict from the
// pixel checker. Depends on tgrr_pkg, the block and tgrr_pixel_checker.
`timescale 1ns / 100ps

module tb_top;
  import tgrr_pkg::*;

  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 20;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [AttrW-1:0]   cfg_wdata_i;
  logic               s_axis_tvalid_i;
  logic               s_axis_tready_o;
  logic [15:0]        s_axis_tdata_i;  // [15:0] glyph_row
  logic               s_axis_tuser_i;  // [0] first_row
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i;
  logic [7:0]         m_axis_tdata_o;  // [3:0] pixel_colour, [7:4] zero
  logic               m_axis_tlast_o;

  int errors;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  // number of long hold-offs requested by the stimulus
  int hold_reqs;

  text_glyph_row_renderer_top u_top (.*);

  tgrr_pixel_checker u_checker (
    .errors_o  (errors),
    .pending_o (pending),
    .*
  );

  // 50 MHz clock
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin : watchdog
    #5_000_000;
    $display("[text_glyph_row_renderer_top] ERROR");
    $finish;
  end

  // Output back-pressure; a long hold-off is counted here
  initial begin : receiver
    int held;
    int served;
    held   = 0;
    served = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_reqs != served) begin
        m_axis_tready_i <= 1'b0;
        held++;
        if (held == HoldCycles) begin
          held = 0;
          served++;
        end
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Offer one row, with random idle cycles ahead; called and returns at negedge
  task automatic send_row(input logic [15:0] row, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= row;
    s_axis_tuser_i  <= first;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [AttrW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [7:0] colour, input logic inv,
                                input logic shade, input logic mode,
                                input logic [4:0] width);
    write_reg(REG_TEXT_COLOUR, colour);
    write_reg(REG_INVERT_ENABLE, {7'd0, inv});
    write_reg(REG_SHADE_ENABLE, {7'd0, shade});
    write_reg(REG_TEXT_MODE, {7'd0, mode});
    write_reg(REG_GLYPH_WIDTH, {3'd0, width});
    cfg_we_i <= 1'b0;
  endtask

  // Stop offering rows, wait for every pixel, then let the pipeline settle
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // One random phase: fresh settings, then glyphs of random height
  task automatic run_random(input int items, input int idle_pct, input int stall_pct,
                            input bit hold);
    int sent;
    int rows;
    int pick;
    logic [4:0] width;
    logic first;
    wait_idle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pick = $urandom_range(99);
    if (pick < 65)      width = 5'($urandom_range(16, 1));
    else if (pick < 80) width = 5'd8;
    else if (pick < 88) width = 5'd0;
    else                width = 5'($urandom_range(31, 17));
    apply_settings(8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)), width);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_reqs++;
    sent = 0;
    while (sent < items) begin
      rows = $urandom_range(12, 1);
      for (int r = 0; r < rows && sent < items; r++) begin
        first = (r == 0);
        // occasional stray first_row flags and missing glyph starts
        if ($urandom_range(9) == 0) first = 1'($urandom_range(1));
        send_row(16'($urandom_range(65535)), first);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = REG_TEXT_COLOUR;
    cfg_wdata_i     = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_reqs       = 0;
    rst_ni          = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: white on black, eight pixels
    send_row(16'hFFFF, 1'b1);
    send_row(16'h0000, 1'b0);
    send_row(16'h8001, 1'b0);

    // Attribute bit 7 is ignored while both enables are off
    wait_idle();
    apply_settings(8'hFF, 1'b0, 1'b0, 1'b0, 5'd16);
    send_row(16'hA5C3, 1'b0);
    send_row(16'h0001, 1'b1);

    // Shading with attribute bit 7 inversion outside text mode
    wait_idle();
    apply_settings(8'hDA, 1'b0, 1'b1, 1'b0, 5'd16);
    send_row(16'h0000, 1'b1);
    send_row(16'h0000, 1'b0);
    send_row(16'hFFFF, 1'b0);
    send_row(16'h1234, 1'b1);

    // Text mode blocks bit 7 inversion; width above the limit is clamped
    wait_idle();
    apply_settings(8'hDA, 1'b0, 1'b1, 1'b1, 5'd17);
    send_row(16'h0F0F, 1'b1);
    send_row(16'hF0F0, 1'b0);

    // Explicit inversion, single pixel rows
    wait_idle();
    apply_settings(8'h70, 1'b1, 1'b0, 1'b1, 5'd1);
    send_row(16'h8000, 1'b0);
    send_row(16'h7FFF, 1'b0);

    // Zero width emits nothing but still advances the shade phase
    wait_idle();
    apply_settings(8'h3C, 1'b1, 1'b1, 1'b0, 5'd0);
    send_row(16'hFFFF, 1'b1);
    send_row(16'h0000, 1'b0);
    wait_idle();
    apply_settings(8'h3C, 1'b1, 1'b1, 1'b0, 5'd31);
    send_row(16'h0000, 1'b0);
    send_row(16'hAAAA, 1'b0);

    // Random phases across the idling mixes; the first one holds the output off
    run_random(19, 0, 0, 1'b1);
    run_random(19, 0, 0, 1'b0);
    run_random(19, 56, 0, 1'b0);
    run_random(19, 56, 0, 1'b0);
    run_random(19, 0, 56, 1'b0);
    run_random(19, 0, 56, 1'b0);
    run_random(19, 8, 8, 1'b0);
    run_random(19, 8, 8, 1'b0);

    wait_idle();
    if (errors == 0) begin
      $display("[text_glyph_row_renderer_top] OK");
    end else begin
      $display("[text_glyph_row_renderer_top] ERROR");
    end
    $finish;
  end

endmodule
